// ===== sv/lfu_et_pkg.sv =====
package lfu_et_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int KEY_BITS    = 32;
   localparam int SLOT_BITS   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int COUNT_BITS  = 32;
   localparam int PORT_BITS   = 32;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [SLOT_BITS:0]    slot_cnt_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_ACCESS = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } ctl_state_type;

   // one table row as held in the key/count RAM
   typedef struct packed {
      key_type   key;
      count_type count;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctl_status_type;

   localparam slot_cnt_type SLOTS_END = slot_cnt_type'(TABLE_SLOTS);

   function automatic key_type key_from_port(logic [PORT_BITS-1:0] v);
      logic [KEY_BITS+PORT_BITS-1:0] wide;
      wide = {{KEY_BITS{1'b0}}, v};
      return wide[KEY_BITS-1:0];
   endfunction

   function automatic logic [PORT_BITS-1:0] key_to_port(key_type k);
      logic [KEY_BITS+PORT_BITS-1:0] wide;
      wide = {{PORT_BITS{1'b0}}, k};
      return wide[PORT_BITS-1:0];
   endfunction

endpackage

// ===== sv/lfu_eviction_tracker_unit.sv =====
// LFU eviction tracker. A command is taken when start is high and busy is low.
// Each command walks the whole key/count table, one RAM row per cycle, through
// the single read port of the key/count RAM, then writes the table and registers
// the result strobe rsp_valid; busy drops in the same cycle that rsp_valid rises
// and the next command can be taken there. rsp_valid is high for exactly one cycle and
// cannot be held off: capture the rsp_ fields in that cycle. The byte budget
// is to be written through csr_valid/csr_ready (always ready) while busy is
// low; the block itself does not enforce this. Reset clears the table flags
// and the used-memory total; no clearing pass.
module lfu_eviction_tracker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_item_key,
   input  logic [31:0] req_value_bytes,
   input  logic [31:0] req_use_count,
   output logic        rsp_valid,
   output logic        rsp_key_hit,
   output logic        rsp_victim_valid,
   output logic [31:0] rsp_victim_key,
   output logic        rsp_over_limit,
   output logic [31:0] rsp_used_bytes,
   output logic        rsp_table_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_memory_limit
);

   import lfu_et_pkg::*;

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;

   assign csr_ready = 1'b1;

   lfu_et_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (ctl_status),
      .cmd    (ctl_cmd)
   );

   lfu_et_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctl_cmd),
      .status           (ctl_status),
      .req_command      (req_command),
      .req_item_key     (req_item_key),
      .req_value_bytes  (req_value_bytes),
      .req_use_count    (req_use_count),
      .csr_write        (csr_valid && csr_ready),
      .csr_memory_limit (csr_memory_limit),
      .rsp_valid        (rsp_valid),
      .rsp_key_hit      (rsp_key_hit),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_key   (rsp_victim_key),
      .rsp_over_limit   (rsp_over_limit),
      .rsp_used_bytes   (rsp_used_bytes),
      .rsp_table_full   (rsp_table_full)
   );

endmodule

// ===== sv/lfu_et_ram.sv =====
module lfu_et_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [WIDTH-1:0]                wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lfu_et_ctrl.sv =====
module lfu_et_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lfu_et_pkg::ctl_status_type   status,
   output lfu_et_pkg::ctl_cmd_type      cmd
);

   import lfu_et_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.update = (state_ff == ST_UPDATE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/lfu_et_dp.sv =====
module lfu_et_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  lfu_et_pkg::ctl_cmd_type      cmd,
   output lfu_et_pkg::ctl_status_type   status,
   input  logic [1:0]                   req_command,
   input  logic [31:0]                  req_item_key,
   input  logic [31:0]                  req_value_bytes,
   input  logic [31:0]                  req_use_count,
   input  logic                         csr_write,
   input  logic [31:0]                  csr_memory_limit,
   output logic                         rsp_valid,
   output logic                         rsp_key_hit,
   output logic                         rsp_victim_valid,
   output logic [31:0]                  rsp_victim_key,
   output logic                         rsp_over_limit,
   output logic [31:0]                  rsp_used_bytes,
   output logic                         rsp_table_full
);

   import lfu_et_pkg::*;

   // request hold
   cmd_type      req_cmd_ff,   req_cmd_in;
   key_type      req_key_ff,   req_key_in;
   logic [31:0]  req_bytes_ff, req_bytes_in;
   count_type    req_count_ff, req_count_in;

   // table flags and totals
   logic [TABLE_SLOTS-1:0] used_ff,  used_in;
   logic [TABLE_SLOTS-1:0] elig_ff,  elig_in;
   logic [31:0]            total_ff, total_in;
   logic [31:0]            limit_ff, limit_in;

   // scan pipeline
   slot_cnt_type rd_idx_ff,  rd_idx_in;
   logic         cmp_vld_ff, cmp_vld_in;
   slot_type     cmp_idx_ff, cmp_idx_in;

   // scan findings
   logic      hit_found_ff,  hit_found_in;
   slot_type  hit_idx_ff,    hit_idx_in;
   logic      free_found_ff, free_found_in;
   slot_type  free_idx_ff,   free_idx_in;
   logic      best_found_ff, best_found_in;
   slot_type  best_idx_ff,   best_idx_in;
   count_type best_count_ff, best_count_in;
   key_type   best_key_ff,   best_key_in;

   // result registers
   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_hit_ff,    rsp_hit_in;
   logic        rsp_vvalid_ff, rsp_vvalid_in;
   logic [31:0] rsp_vkey_ff,   rsp_vkey_in;
   logic        rsp_over_ff,   rsp_over_in;
   logic [31:0] rsp_used_ff,   rsp_used_in;
   logic        rsp_full_ff,   rsp_full_in;

   // RAM port signals
   logic      ram_we;
   slot_type  ram_wr_addr;
   entry_type ram_wr_data;
   logic      ram_re;
   slot_type  ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_data;

   entry_type   rd_entry;
   slot_type    wr_slot;
   logic [32:0] sum_wide;

   lfu_et_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign status.scan_done = (rd_idx_ff == SLOTS_END) && !cmp_vld_ff;
   assign sum_wide = {1'b0, total_ff} + {1'b0, req_bytes_ff};
   assign rd_entry = entry_type'(ram_rd_data);

   always_comb begin
      req_cmd_in    = req_cmd_ff;
      req_key_in    = req_key_ff;
      req_bytes_in  = req_bytes_ff;
      req_count_in  = req_count_ff;
      used_in       = used_ff;
      elig_in       = elig_ff;
      total_in      = total_ff;
      limit_in      = limit_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = rd_idx_ff[SLOT_BITS-1:0];
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_count_in = best_count_ff;
      best_key_in   = best_key_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_vkey_in   = rsp_vkey_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_full_in   = rsp_full_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = '{key: req_key_ff, count: req_count_ff};
      ram_re        = 1'b0;
      ram_rd_addr   = rd_idx_ff[SLOT_BITS-1:0];
      wr_slot       = hit_idx_ff;

      if (csr_write) begin
         limit_in = csr_memory_limit;
      end

      if (cmd.load) begin
         req_cmd_in    = cmd_type'(req_command);
         req_key_in    = key_from_port(req_item_key);
         req_bytes_in  = req_value_bytes;
         req_count_in  = req_use_count;
         rd_idx_in     = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         best_found_in = 1'b0;
      end

      if (cmd.scan) begin
         // issue one RAM read per cycle, compare the row read last cycle
         if (rd_idx_ff != SLOTS_END) begin
            ram_re     = 1'b1;
            cmp_vld_in = 1'b1;
            rd_idx_in  = rd_idx_ff + 1'b1;
         end
         if (cmp_vld_ff) begin
            if (used_ff[cmp_idx_ff]) begin
               if (!hit_found_ff && (rd_entry.key == req_key_ff)) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = cmp_idx_ff;
               end
               // strict less-than keeps the lowest slot on ties
               if (elig_ff[cmp_idx_ff] &&
                   (!best_found_ff || (rd_entry.count < best_count_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in   = cmp_idx_ff;
                  best_count_in = rd_entry.count;
                  best_key_in   = rd_entry.key;
               end
            end else if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
         end
      end

      if (cmd.update) begin
         rsp_valid_in  = 1'b1;
         rsp_vvalid_in = 1'b0;
         rsp_vkey_in   = '0;
         rsp_full_in   = 1'b0;
         unique case (req_cmd_ff)
            CMD_QUERY: begin
               if (best_found_ff) begin
                  elig_in[best_idx_ff] = 1'b0;
                  rsp_vvalid_in        = 1'b1;
                  rsp_vkey_in          = key_to_port(best_key_ff);
               end
            end
            CMD_INSERT: begin
               if (hit_found_ff || free_found_ff) begin
                  wr_slot          = hit_found_ff ? hit_idx_ff : free_idx_ff;
                  ram_we           = 1'b1;
                  ram_wr_addr      = wr_slot;
                  used_in[wr_slot] = 1'b1;
                  elig_in[wr_slot] = 1'b1;
                  total_in         = sum_wide[32] ? '1 : sum_wide[31:0];
               end else begin
                  rsp_full_in = 1'b1;
               end
            end
            CMD_ACCESS: begin
               if (hit_found_ff) begin
                  ram_we              = 1'b1;
                  ram_wr_addr         = hit_idx_ff;
                  elig_in[hit_idx_ff] = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (hit_found_ff) begin
                  used_in[hit_idx_ff] = 1'b0;
                  elig_in[hit_idx_ff] = 1'b0;
                  total_in = (total_ff >= req_bytes_ff) ? (total_ff - req_bytes_ff) : '0;
               end
            end
         endcase
         rsp_hit_in  = hit_found_ff && (req_cmd_ff != CMD_QUERY);
         rsp_over_in = (total_in > limit_ff);
         rsp_used_in = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         elig_ff      <= '0;
         total_ff     <= '0;
         limit_ff     <= '1;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         elig_ff      <= elig_in;
         total_ff     <= total_in;
         limit_ff     <= limit_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_cmd_ff    <= req_cmd_in;
      req_key_ff    <= req_key_in;
      req_bytes_ff  <= req_bytes_in;
      req_count_ff  <= req_count_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_count_ff <= best_count_in;
      best_key_ff   <= best_key_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_vkey_ff   <= rsp_vkey_in;
      rsp_over_ff   <= rsp_over_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_hit      = rsp_hit_ff;
   assign rsp_victim_valid = rsp_vvalid_ff;
   assign rsp_victim_key   = rsp_vkey_ff;
   assign rsp_over_limit   = rsp_over_ff;
   assign rsp_used_bytes   = rsp_used_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

// ===== sv/lfu_et_checker.sv =====
module lfu_et_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_key_hit,
   input logic        rsp_victim_valid,
   input logic        rsp_table_full
);

   // a taken command keeps the block busy through its table walk
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // the result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the end of a command always delivers its result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result transfer");

   // a query names no key, so no hit alongside a victim
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_victim_valid && rsp_key_hit))
      else $error("victim reported together with key hit");

   // a dropped insert was a miss and no query
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (!rsp_key_hit && !rsp_victim_valid))
      else $error("table full flagged on a hit or query");

endmodule

bind lfu_eviction_tracker_unit lfu_et_checker u_lfu_et_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_key_hit      (rsp_key_hit),
   .rsp_victim_valid (rsp_victim_valid),
   .rsp_table_full   (rsp_table_full)
);

// ===== test/lfu_eviction_tracker_tb.sv =====
module testbench;
   import lfu_et_pkg::*;

   typedef struct packed {
      logic        key_hit;
      logic        victim_valid;
      logic [31:0] victim_key;
      logic        over_limit;
      logic [31:0] used_bytes;
      logic        table_full;
   } outcome_type;

   // Tracks the LFU table and memory total, and holds the outcomes still due.
   class lfu_scoreboard;
      bit          slot_live[TABLE_SLOTS];
      bit          slot_ready[TABLE_SLOTS];
      key_type     slot_tag[TABLE_SLOTS];
      count_type   slot_uses[TABLE_SLOTS];
      logic [31:0] budget;
      logic [31:0] total;
      outcome_type pending_outcomes[$];
      int          mismatches;

      function new();
         foreach (slot_live[i]) begin
            slot_live[i] = 0;
            slot_ready[i] = 0;
         end
         budget = '1;
         total = 0;
         mismatches = 0;
      endfunction

      function void set_budget(logic [31:0] value);
         budget = value;
      endfunction

      function void note_command(cmd_type cmd, logic [31:0] item_key,
                                 logic [31:0] value_bytes, logic [31:0] use_count);
         outcome_type o;
         key_type     k;
         int          s;
         int          best;
         int          i;
         o = '0;
         k = key_type'(item_key);
         if (cmd == CMD_QUERY) begin
            best = -1;
            for (i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_live[i] && slot_ready[i] &&
                   (best < 0 || slot_uses[i] < slot_uses[best]))
                  best = i;
            end
            if (best >= 0) begin
               slot_ready[best] = 0;
               o.victim_valid = 1;
               o.victim_key = 32'(slot_tag[best]);
            end
         end else begin
            s = -1;
            for (i = 0; i < TABLE_SLOTS; i++)
               if (s < 0 && slot_live[i] && slot_tag[i] == k)
                  s = i;
            o.key_hit = (s >= 0);
            case (cmd)
               CMD_INSERT: begin
                  for (i = 0; i < TABLE_SLOTS; i++)
                     if (s < 0 && !slot_live[i])
                        s = i;
                  if (s < 0) begin
                     o.table_full = 1;
                  end else begin
                     slot_live[s] = 1;
                     slot_ready[s] = 1;
                     slot_tag[s] = k;
                     slot_uses[s] = use_count;
                     if (total > 32'hFFFF_FFFF - value_bytes)
                        total = 32'hFFFF_FFFF;
                     else
                        total = total + value_bytes;
                  end
               end
               CMD_ACCESS: begin
                  if (s >= 0) begin
                     slot_uses[s] = use_count;
                     slot_ready[s] = 1;
                  end
               end
               default: begin
                  if (s >= 0) begin
                     slot_live[s] = 0;
                     slot_ready[s] = 0;
                     total = (total >= value_bytes) ? total - value_bytes : 32'd0;
                  end
               end
            endcase
         end
         o.over_limit = (total > budget);
         o.used_bytes = total;
         pending_outcomes.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         bit          bad;
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0d vv=%0d vkey=%h over=%0d used=%h full=%0d",
                        got.key_hit, got.victim_valid, got.victim_key, got.over_limit,
                        got.used_bytes, got.table_full);
            return;
         end
         want = pending_outcomes.pop_front();
         bad = 0;
         if (got.key_hit !== want.key_hit) bad = 1;
         if (got.victim_valid !== want.victim_valid) bad = 1;
         if (got.victim_key !== want.victim_key) bad = 1;
         if (got.over_limit !== want.over_limit) bad = 1;
         if (got.used_bytes !== want.used_bytes) bad = 1;
         if (got.table_full !== want.table_full) bad = 1;
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected hit=%0d vv=%0d vkey=%h over=%0d used=%h full=%0d",
                        want.key_hit, want.victim_valid, want.victim_key, want.over_limit,
                        want.used_bytes, want.table_full);
               $display("          actual   hit=%0d vv=%0d vkey=%h over=%0d used=%h full=%0d",
                        got.key_hit, got.victim_valid, got.victim_key, got.over_limit,
                        got.used_bytes, got.table_full);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_command;
   logic [31:0] req_item_key;
   logic [31:0] req_value_bytes;
   logic [31:0] req_use_count;
   logic        rsp_valid;
   logic        rsp_key_hit;
   logic        rsp_victim_valid;
   logic [31:0] rsp_victim_key;
   logic        rsp_over_limit;
   logic [31:0] rsp_used_bytes;
   logic        rsp_table_full;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_memory_limit;

   lfu_scoreboard sb;
   logic [31:0]   key_pool[40];
   int            stall_cycles = 0;

   lfu_eviction_tracker_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_item_key     (req_item_key),
      .req_value_bytes  (req_value_bytes),
      .req_use_count    (req_use_count),
      .rsp_valid        (rsp_valid),
      .rsp_key_hit      (rsp_key_hit),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_key   (rsp_victim_key),
      .rsp_over_limit   (rsp_over_limit),
      .rsp_used_bytes   (rsp_used_bytes),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_memory_limit (csr_memory_limit)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(outcome_type'({rsp_key_hit, rsp_victim_valid, rsp_victim_key,
                                        rsp_over_limit, rsp_used_bytes, rsp_table_full}));
   end

   // End the run when nothing transfers for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= 2000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int idle_gap(bit steady);
      return steady ? 0 : $urandom_range(0, 3);
   endfunction

   // Entered and left just after a falling edge.
   task automatic send_command(cmd_type cmd, logic [31:0] item_key,
                               logic [31:0] value_bytes, logic [31:0] use_count, int gap);
      if (gap > 0) begin
         start = 0;
         repeat (gap) @(negedge clock);
      end
      start = 1;
      req_command = cmd;
      req_item_key = item_key;
      req_value_bytes = value_bytes;
      req_use_count = use_count;
      do @(posedge clock); while (busy);
      sb.note_command(cmd, item_key, value_bytes, use_count);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start = 0;
      while (sb.pending_outcomes.size() != 0 || busy)
         @(negedge clock);
   endtask

   task automatic write_budget(logic [31:0] value);
      csr_valid = 1;
      csr_memory_limit = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_budget(value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic run_directed();
      int i;
      send_command(CMD_QUERY, 32'h0, 32'h0, 32'h0, idle_gap(0));
      send_command(CMD_ACCESS, 32'h0000_1234, 32'h0, 32'h9, idle_gap(0));
      send_command(CMD_DELETE, 32'h0000_1234, 32'h40, 32'h0, idle_gap(0));
      send_command(CMD_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF, idle_gap(0));
      send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, idle_gap(0));
      for (i = 2; i < TABLE_SLOTS; i++)
         send_command(CMD_INSERT, 32'h1000 + i, 32'd100, 32'd7, idle_gap(0));
      // table is full: a new key is dropped, a tracked one still lands
      send_command(CMD_INSERT, 32'h5A5A_0001, 32'd50, 32'd1, idle_gap(0));
      send_command(CMD_INSERT, 32'h0, 32'd3, 32'h0, idle_gap(0));
      // two slots tie at count zero: the lower slot goes first
      send_command(CMD_QUERY, 32'h0, 32'h0, 32'h0, idle_gap(0));
      send_command(CMD_DELETE, 32'hFFFF_FFFF, 32'd1, 32'h0, idle_gap(0));
      send_command(CMD_DELETE, 32'h0, 32'hFFFF_FFFF, 32'h0, idle_gap(0));
      send_command(CMD_QUERY, 32'h0, 32'h0, 32'h0, idle_gap(0));
   endtask

   task automatic run_random(int count, int pool_size, bit steady);
      int          i;
      int          r;
      cmd_type     cmd;
      logic [31:0] item_key;
      logic [31:0] value_bytes;
      logic [31:0] use_count;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35)
            cmd = CMD_INSERT;
         else if (r < 55)
            cmd = CMD_ACCESS;
         else if (r < 75)
            cmd = CMD_DELETE;
         else
            cmd = CMD_QUERY;
         if ($urandom_range(0, 9) == 0)
            item_key = $urandom;
         else
            item_key = key_pool[$urandom_range(0, pool_size - 1)];
         r = $urandom_range(0, 9);
         if (r < 7)
            value_bytes = $urandom_range(0, 5000);
         else if (r < 9)
            value_bytes = $urandom;
         else
            value_bytes = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         r = $urandom_range(0, 9);
         if (r < 5)
            use_count = $urandom_range(0, 15);
         else if (r < 9)
            use_count = $urandom;
         else
            use_count = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         // hold back-to-back transfers through part of each phase
         send_command(cmd, item_key, value_bytes, use_count,
                      idle_gap(steady || ((i / 60) % 4 == 1)));
      end
   endtask

   initial begin
      sb = new();
      reset = 1;
      start = 0;
      req_command = CMD_INSERT;
      req_item_key = 0;
      req_value_bytes = 0;
      req_use_count = 0;
      csr_valid = 0;
      csr_memory_limit = 0;
      foreach (key_pool[i])
         key_pool[i] = $urandom;
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      run_directed();
      wait_drained();
      write_budget(32'h0);
      run_random(300, 12, 0);
      wait_drained();
      write_budget(32'hFFFF_FFFF);
      run_random(300, 40, 1);
      wait_drained();
      write_budget(32'd20000);
      run_random(300, 20, 0);
      wait_drained();
      write_budget($urandom);
      run_random(300, 24, 0);
      wait_drained();
      write_budget(32'd3000);
      run_random(300, 16, 0);
      wait_drained();
      repeat (40) @(posedge clock);

      if (sb.pending_outcomes.size() != 0)
         $display("%0d results never arrived", sb.pending_outcomes.size());
      if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
